>>> rtl/core/bcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared constants, request codes, opcode codes and the font table for the
// bytecode processor core.
// ----------------------------------------------------------------------------
package bcc_pkg;

	localparam int MEM_BYTES     = 4096;
	localparam int MEM_AW        = $clog2(MEM_BYTES);
	localparam int STACK_DEPTH   = 16;
	localparam int SP_W          = $clog2(STACK_DEPTH);
	localparam int SCREEN_WIDTH  = 64;
	localparam int COL_W         = $clog2(SCREEN_WIDTH);
	localparam int SCREEN_PIXELS = 2048;
	localparam int PIX_AW        = $clog2(SCREEN_PIXELS);
	localparam int ROW_W         = PIX_AW - COL_W;
	localparam int PROGRAM_START = 512;
	localparam int FONT_BYTES    = 80;
	localparam int FONT_AW       = $clog2(FONT_BYTES);

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_EXEC  = 2'd1,
		REQ_READ  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;

	localparam logic [7:0] KEY_DOWN_SKIP = 8'h9E;
	localparam logic [7:0] KEY_UP_SKIP   = 8'hA1;
	localparam logic [7:0] F_GET_DELAY   = 8'h07;
	localparam logic [7:0] F_KEY_WAIT    = 8'h0A;
	localparam logic [7:0] F_SET_DELAY   = 8'h15;
	localparam logic [7:0] F_SET_SOUND   = 8'h18;
	localparam logic [7:0] F_ADD_INDEX   = 8'h1E;
	localparam logic [7:0] F_FONT_ADDR   = 8'h29;
	localparam logic [7:0] F_BCD         = 8'h33;
	localparam logic [7:0] F_STORE       = 8'h55;
	localparam logic [7:0] F_LOAD        = 8'h65;

	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_RSB = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	localparam logic [3:0] REG_FLAG = 4'hF;

	localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	function automatic logic [7:0] font_byte(input logic [MEM_AW-1:0] a);
		logic [7:0] b;
		b = 8'd0;
		if (a < MEM_AW'(FONT_BYTES)) begin
			b = FONT_ROM[a[FONT_AW-1:0]];
		end
		return b;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/bytecode_cpu_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bytecode_cpu_core
// CHIP-8 style processor core: 4 KiB memory, sixteen data registers, call
// stack, timers and a 64x32 display, run by a small multi-cycle sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one request transaction:
//   write a memory byte, execute one instruction, or read a display pixel.
//   Output channel (out_valid/out_stall) returns one result transaction per
//   request: pc_now, pixel_value and the status flags.
//   Only one request is in flight; in_stall is high until it has finished.
//   Sequence: an instruction makes two opcode fetches and three register
//   reads over the single register port before it executes. Sprite draw
//   loads each row, visits each sprite bit and, for each set bit, reads
//   then writes the display port. FX55/FX65 take a read and a write step
//   per register. Display clear walks all 2048 pixels, one per cycle.
//   After reset the core sweeps its 4096 memory bytes (font in the first
//   80) and the display, one entry a cycle, with in_stall high throughout.
//   A result waits in the output register while out_stall is high;
//   the next request is not finished until that result has been taken.
// ----------------------------------------------------------------------------
module bytecode_cpu_core
	import bcc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [11:0] address,
	input  wire logic [7:0]  write_data,
	input  wire logic [15:0] keys_down,
	input  wire logic [7:0]  random_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [11:0]      pc_now,
	output logic             pixel_value,
	output logic             display_changed,
	output logic             sound_active,
	output logic             bad_opcode,
	output logic             key_waiting
);

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_F1, S_F2, S_RX, S_RY, S_RZ, S_EXEC, S_WF, S_DCLR,
		S_DROW, S_DLOAD, S_DPIX, S_DTOG, S_DFIN, S_B1, S_B2, S_B3,
		S_W55A, S_W55B, S_L65A, S_L65B, S_PIX, S_FIN
	} state_t;

	state_t state_q;

	logic [MEM_AW-1:0] clr_q;
	logic [11:0]       pc_q;
	logic [15:0]       i_q;
	logic [SP_W-1:0]   sp_q;
	logic [7:0]        dt_q;
	logic [7:0]        st_q;
	logic [7:0]        op_hi_q;
	logic [7:0]        op_lo_q;
	logic [7:0]        vx_q;
	logic [7:0]        vy_q;
	logic [7:0]        v0_q;
	logic [15:0]       keys_q;
	logic [7:0]        rnd_q;
	logic [11:0]       addr_q;
	logic [3:0]        cnt_q;
	logic [3:0]        row_cnt_q;
	logic [2:0]        col_q;
	logic [7:0]        row_q;
	logic              hit_q;
	logic              flag_q;
	logic [6:0]        bcd_r_q;
	logic              exec_q;
	logic              drew_q;
	logic              bad_q;
	logic              wait_q;
	logic              pix_q;
	logic [15:0]       v_ok_q;
	logic [STACK_DEPTH-1:0] stk_ok_q;
	logic              v_rd_ok_q;
	logic              stk_rd_ok_q;

	logic [7:0]  mem_q [MEM_BYTES];
	logic [7:0]  mem_rd_q;
	logic        disp_q [SCREEN_PIXELS];
	logic        disp_rd_q;
	logic [7:0]  v_mem_q [16];
	logic [7:0]  v_rd_q;
	logic [11:0] stk_mem_q [STACK_DEPTH];
	logic [11:0] stk_rd_q;

	logic              out_valid_q;
	logic [11:0]       pc_now_q;
	logic              pixel_value_q;
	logic              display_changed_q;
	logic              sound_active_q;
	logic              bad_opcode_q;
	logic              key_waiting_q;

	logic [15:0] op;
	logic [3:0]  x;
	logic [3:0]  y;
	logic [3:0]  n;
	logic [7:0]  nn;
	logic [11:0] nnn;
	logic [11:0] pc_inc1;
	logic [11:0] pc_next;
	logic [11:0] pc_skip;
	logic [SP_W-1:0] sp_inc;
	logic [SP_W-1:0] sp_dec;
	logic [7:0]  vval;
	logic [11:0] stk_val;
	logic        accept;

	logic [8:0]  sum9;
	logic [16:0] i_sum;
	logic        key_dn;
	logic [3:0]  key_hi;

	logic [11:0] ex_pc;
	logic        ex_bad;
	logic        ex_drew;
	logic        ex_wait;
	logic        ex_vwe;
	logic [3:0]  ex_vwa;
	logic [7:0]  ex_vwd;
	logic        ex_fwe;
	logic        ex_flag;
	logic        ex_iwe;
	logic [15:0] ex_ival;
	logic        ex_push;
	logic        ex_pop;
	logic        ex_dwe;
	logic        ex_swe;
	state_t      ex_nxt;

	logic              mem_we;
	logic [MEM_AW-1:0] mem_wa;
	logic [7:0]        mem_wd;
	logic [MEM_AW-1:0] mem_ra;
	logic              disp_we;
	logic [PIX_AW-1:0] disp_wa;
	logic              disp_wd;
	logic [PIX_AW-1:0] disp_ra;
	logic              v_we;
	logic [3:0]        v_wa;
	logic [7:0]        v_wd;
	logic [3:0]        v_ra;

	logic [8:0]        px_x;
	logic [ROW_W-1:0]  px_y;
	logic [PIX_AW-1:0] px_a;
	logic              last_col;
	logic              last_row;
	logic [1:0]        bcd_h;
	logic [7:0]        bcd_rem;
	logic [14:0]       tens_prod;
	logic [3:0]        tens;
	logic [6:0]        ones7;

	assign op      = {op_hi_q, op_lo_q};
	assign x       = op_hi_q[3:0];
	assign y       = op_lo_q[7:4];
	assign n       = op_lo_q[3:0];
	assign nn      = op_lo_q;
	assign nnn     = {op_hi_q[3:0], op_lo_q};
	assign pc_inc1 = pc_q + 12'd1;
	assign pc_next = pc_q + 12'd2;
	assign pc_skip = pc_q + 12'd4;
	assign sp_inc  = (sp_q == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_q + SP_W'(1);
	assign sp_dec  = (sp_q == '0) ? SP_W'(STACK_DEPTH - 1) : sp_q - SP_W'(1);
	assign vval    = v_rd_ok_q ? v_rd_q : 8'd0;
	assign stk_val = stk_rd_ok_q ? stk_rd_q : 12'd0;
	assign in_stall = (state_q != S_IDLE);
	assign accept  = in_valid && (state_q == S_IDLE);

	assign sum9   = {1'b0, vx_q} + {1'b0, vy_q};
	assign i_sum  = {1'b0, i_q} + {9'd0, vx_q};
	assign key_dn = keys_q[vx_q[3:0]];

	always_comb begin
		key_hi = 4'd0;
		for (int k = 0; k < 16; k++) begin
			if (keys_q[k]) begin
				key_hi = 4'(k);
			end
		end
	end

	// sprite pixel address and bcd digits
	assign px_x      = {1'b0, vx_q} + {6'd0, col_q};
	assign px_y      = vy_q[ROW_W-1:0] + ROW_W'(row_cnt_q);
	assign px_a      = {px_y, COL_W'(0)} + PIX_AW'(px_x);
	assign last_col  = (col_q == 3'd7);
	assign last_row  = (row_cnt_q == n - 4'd1);
	assign bcd_h     = (vx_q >= 8'd200) ? 2'd2 : ((vx_q >= 8'd100) ? 2'd1 : 2'd0);
	assign bcd_rem   = vx_q - ((bcd_h == 2'd2) ? 8'd200 : ((bcd_h == 2'd1) ? 8'd100 : 8'd0));
	assign tens_prod = 15'(bcd_r_q) * 15'd205;
	assign tens      = tens_prod[14:11];
	assign ones7     = bcd_r_q - 7'({3'd0, tens} * 7'd10);

	// instruction decode and alu
	always_comb begin
		ex_pc   = pc_next;
		ex_bad  = 1'b0;
		ex_drew = 1'b0;
		ex_wait = 1'b0;
		ex_vwe  = 1'b0;
		ex_vwa  = x;
		ex_vwd  = 8'd0;
		ex_fwe  = 1'b0;
		ex_flag = 1'b0;
		ex_iwe  = 1'b0;
		ex_ival = i_q;
		ex_push = 1'b0;
		ex_pop  = 1'b0;
		ex_dwe  = 1'b0;
		ex_swe  = 1'b0;
		ex_nxt  = S_FIN;
		case (op_hi_q[7:4])
			4'h0: begin
				if (op == OP_CLS) begin
					ex_drew = 1'b1;
					ex_nxt  = S_DCLR;
				end else if (op == OP_RET) begin
					ex_pc  = stk_val + 12'd2;
					ex_pop = 1'b1;
				end else begin
					ex_bad = 1'b1;
					ex_pc  = pc_q;
				end
			end
			4'h1: ex_pc = nnn;
			4'h2: begin
				ex_push = 1'b1;
				ex_pc   = nnn;
			end
			4'h3: ex_pc = (vx_q == nn) ? pc_skip : pc_next;
			4'h4: ex_pc = (vx_q != nn) ? pc_skip : pc_next;
			4'h5: ex_pc = (vx_q == vy_q) ? pc_skip : pc_next;
			4'h6: begin
				ex_vwe = 1'b1;
				ex_vwd = nn;
			end
			4'h7: begin
				ex_vwe = 1'b1;
				ex_vwd = vx_q + nn;
			end
			4'h8: begin
				ex_vwe = 1'b1;
				ex_fwe = 1'b1;
				case (n)
					ALU_MOV: begin
						ex_vwd = vy_q;
						ex_fwe = 1'b0;
					end
					ALU_OR:  ex_vwd = vx_q | vy_q;
					ALU_AND: ex_vwd = vx_q & vy_q;
					ALU_XOR: ex_vwd = vx_q ^ vy_q;
					ALU_ADD: begin
						ex_vwd  = sum9[7:0];
						ex_flag = sum9[8];
					end
					ALU_SUB: begin
						ex_vwd  = vx_q - vy_q;
						ex_flag = (vx_q >= vy_q);
					end
					ALU_SHR: begin
						ex_vwd  = {1'b0, vx_q[7:1]};
						ex_flag = vx_q[0];
					end
					ALU_RSB: begin
						ex_vwd  = vy_q - vx_q;
						ex_flag = (vy_q >= vx_q);
					end
					ALU_SHL: begin
						ex_vwd  = {vx_q[6:0], 1'b0};
						ex_flag = vx_q[7];
					end
					default: begin
						ex_vwe = 1'b0;
						ex_fwe = 1'b0;
						ex_bad = 1'b1;
						ex_pc  = pc_q;
					end
				endcase
			end
			4'h9: ex_pc = (vx_q != vy_q) ? pc_skip : pc_next;
			4'hA: begin
				ex_iwe  = 1'b1;
				ex_ival = {4'd0, nnn};
			end
			4'hB: ex_pc = nnn + {4'd0, v0_q};
			4'hC: begin
				ex_vwe = 1'b1;
				ex_vwd = rnd_q & nn;
			end
			4'hD: begin
				ex_drew = 1'b1;
				ex_nxt  = (n == 4'd0) ? S_DFIN : S_DROW;
			end
			4'hE: begin
				if (nn == KEY_DOWN_SKIP) begin
					ex_pc = key_dn ? pc_skip : pc_next;
				end else if (nn == KEY_UP_SKIP) begin
					ex_pc = key_dn ? pc_next : pc_skip;
				end else begin
					ex_bad = 1'b1;
					ex_pc  = pc_q;
				end
			end
			default: begin
				case (nn)
					F_GET_DELAY: begin
						ex_vwe = 1'b1;
						ex_vwd = dt_q;
					end
					F_KEY_WAIT: begin
						if (keys_q == 16'd0) begin
							ex_wait = 1'b1;
							ex_pc   = pc_q;
						end else begin
							ex_vwe = 1'b1;
							ex_vwd = {4'd0, key_hi};
						end
					end
					F_SET_DELAY: ex_dwe = 1'b1;
					F_SET_SOUND: ex_swe = 1'b1;
					F_ADD_INDEX: begin
						ex_iwe  = 1'b1;
						ex_ival = i_sum[15:0];
						ex_vwe  = 1'b1;
						ex_vwa  = REG_FLAG;
						ex_vwd  = {7'd0, (i_sum[16:12] != 5'd0)};
					end
					F_FONT_ADDR: begin
						ex_iwe  = 1'b1;
						ex_ival = {6'd0, vx_q, 2'd0} + {8'd0, vx_q};
					end
					F_BCD:   ex_nxt = S_B1;
					F_STORE: ex_nxt = S_W55A;
					F_LOAD:  ex_nxt = S_L65A;
					default: begin
						ex_bad = 1'b1;
						ex_pc  = pc_q;
					end
				endcase
			end
		endcase
	end

	// memory, display and register file port selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = i_q[MEM_AW-1:0];
		mem_wd = 8'd0;
		mem_ra = pc_q;
		case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = font_byte(clr_q);
			end
			S_IDLE: begin
				mem_we = accept && (req_type == REQ_WRITE);
				mem_wa = address;
				mem_wd = write_data;
			end
			S_F1:   mem_ra = pc_inc1;
			S_DROW: mem_ra = i_q[MEM_AW-1:0] + MEM_AW'(row_cnt_q);
			S_L65A: mem_ra = i_q[MEM_AW-1:0] + MEM_AW'(cnt_q);
			S_B1: begin
				mem_we = 1'b1;
				mem_wd = {6'd0, bcd_h};
			end
			S_B2: begin
				mem_we = 1'b1;
				mem_wa = i_q[MEM_AW-1:0] + MEM_AW'(1);
				mem_wd = {4'd0, tens};
			end
			S_B3: begin
				mem_we = 1'b1;
				mem_wa = i_q[MEM_AW-1:0] + MEM_AW'(2);
				mem_wd = {4'd0, ones7[3:0]};
			end
			S_W55B: begin
				mem_we = 1'b1;
				mem_wa = i_q[MEM_AW-1:0] + MEM_AW'(cnt_q);
				mem_wd = vval;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_comb begin
		disp_we = 1'b0;
		disp_wa = px_a;
		disp_wd = 1'b0;
		disp_ra = px_a;
		case (state_q)
			S_CLR, S_DCLR: begin
				disp_we = 1'b1;
				disp_wa = clr_q[PIX_AW-1:0];
			end
			S_IDLE: disp_ra = address[PIX_AW-1:0];
			S_DTOG: begin
				disp_we = 1'b1;
				disp_wd = ~disp_rd_q;
			end
			default: disp_we = 1'b0;
		endcase
	end

	always_comb begin
		v_we = 1'b0;
		v_wa = REG_FLAG;
		v_wd = 8'd0;
		v_ra = x;
		case (state_q)
			S_RX:   v_ra = y;
			S_RY:   v_ra = 4'd0;
			S_W55A: v_ra = cnt_q;
			S_EXEC: begin
				v_we = ex_vwe;
				v_wa = ex_vwa;
				v_wd = ex_vwd;
			end
			S_WF: begin
				v_we = 1'b1;
				v_wd = {7'd0, flag_q};
			end
			S_DFIN: begin
				v_we = 1'b1;
				v_wd = {7'd0, hit_q};
			end
			S_L65B: begin
				v_we = 1'b1;
				v_wa = cnt_q;
				v_wd = mem_rd_q;
			end
			default: v_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		mem_rd_q <= mem_q[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (disp_we) begin
			disp_q[disp_wa] <= disp_wd;
		end
		disp_rd_q <= disp_q[disp_ra];
	end

	always_ff @(posedge clk) begin
		if (v_we) begin
			v_mem_q[v_wa] <= v_wd;
		end
		v_rd_q <= v_mem_q[v_ra];
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_EXEC) && ex_push) begin
			stk_mem_q[sp_q] <= pc_q;
		end
		stk_rd_q <= stk_mem_q[sp_dec];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_CLR;
			clr_q             <= '0;
			pc_q              <= 12'(PROGRAM_START);
			i_q               <= 16'd0;
			sp_q              <= '0;
			dt_q              <= 8'd0;
			st_q              <= 8'd0;
			v_ok_q            <= 16'd0;
			stk_ok_q          <= '0;
			v_rd_ok_q         <= 1'b0;
			stk_rd_ok_q       <= 1'b0;
			exec_q            <= 1'b0;
			drew_q            <= 1'b0;
			bad_q             <= 1'b0;
			wait_q            <= 1'b0;
			pix_q             <= 1'b0;
			hit_q             <= 1'b0;
			flag_q            <= 1'b0;
			cnt_q             <= 4'd0;
			row_cnt_q         <= 4'd0;
			col_q             <= 3'd0;
			out_valid_q       <= 1'b0;
			pc_now_q          <= 12'd0;
			pixel_value_q     <= 1'b0;
			display_changed_q <= 1'b0;
			sound_active_q    <= 1'b0;
			bad_opcode_q      <= 1'b0;
			key_waiting_q     <= 1'b0;
		end else begin
			v_rd_ok_q   <= v_ok_q[v_ra];
			stk_rd_ok_q <= stk_ok_q[sp_dec];
			if (v_we) begin
				v_ok_q[v_wa] <= 1'b1;
			end
			if (out_valid_q && !out_stall && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + MEM_AW'(1);
					if (clr_q == MEM_AW'(MEM_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						addr_q <= address;
						keys_q <= keys_down;
						rnd_q  <= random_byte;
						exec_q <= 1'b0;
						drew_q <= 1'b0;
						bad_q  <= 1'b0;
						wait_q <= 1'b0;
						pix_q  <= 1'b0;
						case (req_type)
							REQ_EXEC: begin
								exec_q  <= 1'b1;
								state_q <= S_F1;
							end
							REQ_READ: state_q <= S_PIX;
							default:  state_q <= S_FIN;
						endcase
					end
				end
				S_F1: begin
					op_hi_q <= mem_rd_q;
					state_q <= S_F2;
				end
				S_F2: begin
					op_lo_q <= mem_rd_q;
					state_q <= S_RX;
				end
				S_RX: begin
					vx_q    <= vval;
					state_q <= S_RY;
				end
				S_RY: begin
					vy_q    <= vval;
					state_q <= S_RZ;
				end
				S_RZ: begin
					v0_q    <= vval;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					pc_q      <= ex_pc;
					bad_q     <= ex_bad;
					drew_q    <= ex_drew;
					wait_q    <= ex_wait;
					flag_q    <= ex_flag;
					cnt_q     <= 4'd0;
					row_cnt_q <= 4'd0;
					col_q     <= 3'd0;
					hit_q     <= 1'b0;
					clr_q     <= '0;
					if (ex_iwe) begin
						i_q <= ex_ival;
					end
					if (ex_push) begin
						stk_ok_q[sp_q] <= 1'b1;
						sp_q           <= sp_inc;
					end
					if (ex_pop) begin
						sp_q <= sp_dec;
					end
					if (ex_dwe) begin
						dt_q <= vx_q;
					end
					if (ex_swe) begin
						st_q <= vx_q;
					end
					state_q <= ex_fwe ? S_WF : ex_nxt;
				end
				S_WF: state_q <= S_FIN;
				S_DCLR: begin
					clr_q <= clr_q + MEM_AW'(1);
					if (clr_q[PIX_AW-1:0] == PIX_AW'(SCREEN_PIXELS - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_DROW: state_q <= S_DLOAD;
				S_DLOAD: begin
					row_q   <= mem_rd_q;
					col_q   <= 3'd0;
					state_q <= S_DPIX;
				end
				S_DPIX, S_DTOG: begin
					if ((state_q == S_DPIX) && row_q[~col_q]) begin
						state_q <= S_DTOG;
					end else begin
						if (state_q == S_DTOG) begin
							hit_q <= hit_q | disp_rd_q;
						end
						col_q <= col_q + 3'd1;
						if (last_col) begin
							row_cnt_q <= row_cnt_q + 4'd1;
							state_q   <= last_row ? S_DFIN : S_DROW;
						end else begin
							state_q <= S_DPIX;
						end
					end
				end
				S_DFIN: state_q <= S_FIN;
				S_B1: begin
					bcd_r_q <= bcd_rem[6:0];
					state_q <= S_B2;
				end
				S_B2: state_q <= S_B3;
				S_B3: state_q <= S_FIN;
				S_W55A: state_q <= S_W55B;
				S_L65A: state_q <= S_L65B;
				S_W55B, S_L65B: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == x) begin
						i_q     <= i_q + {12'd0, x} + 16'd1;
						state_q <= S_FIN;
					end else begin
						state_q <= (state_q == S_W55B) ? S_W55A : S_L65A;
					end
				end
				S_PIX: begin
					pix_q   <= ~addr_q[11] & disp_rd_q;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q       <= 1'b1;
						pc_now_q          <= pc_q;
						pixel_value_q     <= pix_q;
						display_changed_q <= drew_q;
						bad_opcode_q      <= bad_q;
						key_waiting_q     <= wait_q;
						if (exec_q) begin
							sound_active_q <= (st_q > 8'd1);
							if (dt_q != 8'd0) begin
								dt_q <= dt_q - 8'd1;
							end
							if (st_q != 8'd0) begin
								st_q <= st_q - 8'd1;
							end
						end else begin
							sound_active_q <= (st_q != 8'd0);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign pc_now          = pc_now_q;
	assign pixel_value     = pixel_value_q;
	assign display_changed = display_changed_q;
	assign sound_active    = sound_active_q;
	assign bad_opcode      = bad_opcode_q;
	assign key_waiting     = key_waiting_q;

`ifndef SYNTHESIS
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_FIN))
		else $error("result raised outside finish step");

	a_exec_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (req_type == REQ_EXEC)) |=> (state_q == S_F1))
		else $error("execute transaction did not start fetch");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(bad_opcode && (display_changed || key_waiting)))
		else $error("bad opcode reported with other status");

	a_toggle_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DTOG) |-> $past(state_q == S_DPIX))
		else $error("pixel toggle without prior read");
`endif

endmodule
`default_nettype wire

>>> tb/bytecode_cpu_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bytecode_cpu_core_tb
// Drives write, execute and pixel-read requests into the processor core.
// Programs are loaded with memory writes and then stepped one instruction at
// a time. A software copy of the core predicts every result, and the
// scoreboard compares each whole result and reports mismatches by field.
// ----------------------------------------------------------------------------
module bytecode_cpu_core_tb
	import bcc_pkg::*;
();

	typedef struct packed {
		logic [11:0] pc;
		logic        pix;
		logic        drew;
		logic        snd;
		logic        bad;
		logic        wait_key;
	} core_result_t;

	class result_scoreboard;
		core_result_t pending[$];
		int           mismatches;

		function void note_request(core_result_t r);
			pending.push_back(r);
		endfunction

		function void check_result(core_result_t got);
			core_result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result transaction %h", got);
				end
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: pc %h/%h pix %b/%b drew %b/%b snd %b/%b bad %b/%b wait %b/%b",
						want.pc, got.pc, want.pix, got.pix, want.drew, got.drew,
						want.snd, got.snd, want.bad, got.bad, want.wait_key, got.wait_key);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [11:0] address;
	logic [7:0]  write_data;
	logic [15:0] keys_down;
	logic [7:0]  random_byte;
	logic        out_valid;
	logic        out_stall;
	logic [11:0] pc_now;
	logic        pixel_value;
	logic        display_changed;
	logic        sound_active;
	logic        bad_opcode;
	logic        key_waiting;

	bytecode_cpu_core dut (.*);

	result_scoreboard sb;
	int send_idle_pct;
	int stall_pct;

	logic [7:0]  mem_img [MEM_BYTES];
	logic [7:0]  vreg [16];
	logic [11:0] ret_stack [STACK_DEPTH];
	logic [SP_W-1:0] sp;
	logic [11:0] pc;
	logic [15:0] idx;
	logic [7:0]  dly;
	logic [7:0]  snd;
	logic        screen [SCREEN_PIXELS];

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic core_result_t predict_request(logic [1:0] rq, logic [11:0] a,
			logic [7:0] wd, logic [15:0] keys, logic [7:0] rnd);
		core_result_t r;
		logic [15:0] op;
		logic [3:0]  x, y, n;
		logic [7:0]  nn, va, vb, f, bcd;
		logic [11:0] nnn, nx, sk, npc;
		logic [10:0] p;
		logic [16:0] s;
		logic [8:0]  sum;
		r = '0;
		if (rq == REQ_WRITE) begin
			mem_img[a] = wd;
		end else if (rq == REQ_READ) begin
			if (a < 12'(SCREEN_PIXELS)) r.pix = screen[a[10:0]];
		end else if (rq == REQ_EXEC) begin
			op = {mem_img[pc], mem_img[pc + 12'd1]};
			x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0]; nnn = op[11:0];
			nx = pc + 12'd2; sk = pc + 12'd4; npc = nx;
			va = vreg[x]; vb = vreg[y];
			case (op[15:12])
			4'h0: begin
				if (op == OP_CLS) begin
					foreach (screen[i]) screen[i] = 1'b0;
					r.drew = 1'b1;
				end else if (op == OP_RET) begin
					sp = sp - SP_W'(1);
					npc = ret_stack[sp] + 12'd2;
				end else begin
					r.bad = 1'b1; npc = pc;
				end
			end
			4'h1: npc = nnn;
			4'h2: begin
				ret_stack[sp] = pc; sp = sp + SP_W'(1); npc = nnn;
			end
			4'h3: npc = (va == nn) ? sk : nx;
			4'h4: npc = (va != nn) ? sk : nx;
			4'h5: npc = (va == vb) ? sk : nx;
			4'h6: vreg[x] = nn;
			4'h7: vreg[x] = va + nn;
			4'h8: begin
				case (n)
				ALU_MOV: vreg[x] = vb;
				ALU_OR:  begin vreg[x] = va | vb; vreg[REG_FLAG] = 8'd0; end
				ALU_AND: begin vreg[x] = va & vb; vreg[REG_FLAG] = 8'd0; end
				ALU_XOR: begin vreg[x] = va ^ vb; vreg[REG_FLAG] = 8'd0; end
				ALU_ADD: begin
					sum = {1'b0, va} + {1'b0, vb};
					vreg[x] = sum[7:0]; vreg[REG_FLAG] = {7'd0, sum[8]};
				end
				ALU_SUB: begin vreg[x] = va - vb; vreg[REG_FLAG] = {7'd0, va >= vb}; end
				ALU_SHR: begin vreg[x] = va >> 1; vreg[REG_FLAG] = {7'd0, va[0]}; end
				ALU_RSB: begin vreg[x] = vb - va; vreg[REG_FLAG] = {7'd0, vb >= va}; end
				ALU_SHL: begin vreg[x] = va << 1; vreg[REG_FLAG] = {7'd0, va[7]}; end
				default: begin r.bad = 1'b1; npc = pc; end
				endcase
			end
			4'h9: npc = (va != vb) ? sk : nx;
			4'hA: idx = {4'd0, nnn};
			4'hB: npc = nnn + {4'd0, vreg[0]};
			4'hC: vreg[x] = rnd & nn;
			4'hD: begin
				f = 8'd0;
				for (int i = 0; i < n; i++) begin
					bcd = mem_img[12'(idx + 16'(i))];
					for (int j = 0; j < 8; j++) begin
						if (bcd[7-j]) begin
							p = 11'((va + j) + (vb + i) * SCREEN_WIDTH);
							if (screen[p]) f = 8'd1;
							screen[p] = ~screen[p];
						end
					end
				end
				vreg[REG_FLAG] = f;
				r.drew = 1'b1;
			end
			4'hE: begin
				if (nn == KEY_DOWN_SKIP) npc = keys[va[3:0]] ? sk : nx;
				else if (nn == KEY_UP_SKIP) npc = keys[va[3:0]] ? nx : sk;
				else begin r.bad = 1'b1; npc = pc; end
			end
			default: begin
				case (nn)
				F_GET_DELAY: vreg[x] = dly;
				F_KEY_WAIT: begin
					if (keys == 16'd0) begin
						r.wait_key = 1'b1; npc = pc;
					end else begin
						for (int i = 0; i < 16; i++) if (keys[i]) vreg[x] = 8'(i);
					end
				end
				F_SET_DELAY: dly = va;
				F_SET_SOUND: snd = va;
				F_ADD_INDEX: begin
					s = {1'b0, idx} + {9'd0, va};
					idx = s[15:0]; vreg[REG_FLAG] = {7'd0, s > 17'hFFF};
				end
				F_FONT_ADDR: idx = {8'd0, va} * 16'd5;
				F_BCD: begin
					mem_img[idx[11:0]] = 8'(va / 8'd100);
					mem_img[12'(idx + 16'd1)] = 8'((va / 8'd10) % 8'd10);
					mem_img[12'(idx + 16'd2)] = 8'(va % 8'd10);
				end
				F_STORE: begin
					for (int i = 0; i <= x; i++) mem_img[12'(idx + 16'(i))] = vreg[i];
					idx = idx + {12'd0, x} + 16'd1;
				end
				F_LOAD: begin
					for (int i = 0; i <= x; i++) vreg[i] = mem_img[12'(idx + 16'(i))];
					idx = idx + {12'd0, x} + 16'd1;
				end
				default: begin r.bad = 1'b1; npc = pc; end
				endcase
			end
			endcase
			pc = npc;
			if (dly != 8'd0) dly--;
			if (snd != 8'd0) snd--;
		end
		r.pc = pc;
		r.snd = (snd != 8'd0);
		return r;
	endfunction

	task automatic send_request(logic [1:0] rq, logic [11:0] a, logic [7:0] wd,
			logic [15:0] keys, logic [7:0] rnd);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		req_type <= rq;
		address <= a;
		write_data <= wd;
		keys_down <= keys;
		random_byte <= rnd;
		sb.note_request(predict_request(rq, a, wd, keys, rnd));
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic poke(logic [11:0] a, logic [7:0] d);
		send_request(REQ_WRITE, a, d, 16'($urandom), 8'($urandom));
	endtask

	task automatic run_op(logic [15:0] op, logic [15:0] keys, logic [7:0] rnd);
		poke(pc, op[15:8]);
		poke(pc + 12'd1, op[7:0]);
		send_request(REQ_EXEC, 12'($urandom), 8'($urandom), keys, rnd);
	endtask

	function automatic logic [15:0] random_opcode();
		logic [15:0] op;
		logic [7:0] fcodes [11];
		fcodes = '{F_GET_DELAY, F_KEY_WAIT, F_SET_DELAY, F_SET_SOUND, F_ADD_INDEX,
			F_FONT_ADDR, F_BCD, F_STORE, F_LOAD, F_GET_DELAY, F_SET_DELAY};
		op = 16'($urandom);
		case (op[15:12])
		4'h0: op = ($urandom_range(9) == 0) ? op : (op[0] ? OP_CLS : OP_RET);
		4'h8: if ($urandom_range(7) != 0) op[3:0] = 4'($urandom_range(0, 7));
		4'hD: if ($urandom_range(3) != 0) op[3:0] = 4'($urandom_range(0, 4));
		4'hE: if ($urandom_range(7) != 0) op[7:0] = op[0] ? KEY_DOWN_SKIP : KEY_UP_SKIP;
		4'hF: if ($urandom_range(7) != 0) op[7:0] = fcodes[$urandom_range(10)];
		default: ;
		endcase
		if (op[15:12] == 4'h0 && op == OP_CLS && $urandom_range(3) != 0) op = OP_RET;
		return op;
	endfunction

	initial begin
		sb = new();
		sp = '0; pc = 12'(PROGRAM_START); idx = 16'd0; dly = 8'd0; snd = 8'd0;
		foreach (mem_img[i]) mem_img[i] = (i < FONT_BYTES) ? FONT_ROM[i] : 8'h00;
		foreach (vreg[i]) vreg[i] = 8'd0;
		foreach (ret_stack[i]) ret_stack[i] = 12'd0;
		foreach (screen[i]) screen[i] = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		in_valid = 0; req_type = REQ_WRITE; address = 0; write_data = 0;
		keys_down = 0; random_byte = 0; out_stall = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;

		// directed
		send_request(REQ_EXEC, 12'd0, 8'd0, 16'd0, 8'd0);
		send_request(REQ_READ, 12'd2047, 8'd0, 16'd0, 8'd0);
		send_request(REQ_READ, 12'hFFF, 8'd0, 16'd0, 8'd0);
		send_request(REQ_NONE, 12'hABC, 8'hFF, 16'hFFFF, 8'hFF);
		run_op(16'h6FFF, 16'd0, 8'd0);
		run_op(16'h60FF, 16'd0, 8'd0);
		run_op(16'h8F04, 16'd0, 8'd0);
		run_op(16'hA0FF, 16'd0, 8'd0);
		run_op(16'hD0F5, 16'd0, 8'd0);
		run_op(16'hD0F5, 16'd0, 8'd0);
		run_op(16'hD000, 16'd0, 8'd0);
		run_op(16'h8008, 16'd0, 8'd0);
		run_op(16'hF00A, 16'h0000, 8'd0);
		run_op(16'hF30A, 16'h8001, 8'd0);
		run_op(16'hC3A5, 16'd0, 8'hFF);
		run_op(16'hFF18, 16'd0, 8'd0);
		run_op(16'hAFFF, 16'd0, 8'd0);
		run_op(16'hFF1E, 16'd0, 8'd0);
		run_op(16'hFF55, 16'd0, 8'd0);
		run_op(16'hFF65, 16'd0, 8'd0);
		run_op(16'h00E0, 16'd0, 8'd0);
		run_op(16'hBFFF, 16'd0, 8'd0);
		send_request(REQ_READ, 12'd0, 8'd0, 16'd0, 8'd0);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 74; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 74; end
			3: begin send_idle_pct = 7;  stall_pct = 7;  end
			default: begin send_idle_pct = 0; stall_pct = 0; end
			endcase
			for (int k = 0; k < 85; k++) begin
				case ($urandom_range(9))
				0: poke(12'($urandom), 8'($urandom));
				1: send_request(REQ_READ, 12'($urandom), 8'($urandom), 16'($urandom),
					8'($urandom));
				2: send_request(2'($urandom_range(3)), 12'($urandom), 8'($urandom),
					16'($urandom), 8'($urandom));
				default: run_op(random_opcode(), ($urandom_range(3) == 0) ? 16'h0 :
					16'($urandom), 8'($urandom));
				endcase
			end
			if (ph == 1) begin
				in_valid <= 0;
				while (sb.pending.size() != 0) @(posedge clk);
			end
		end

		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				sb.check_result('{pc_now, pixel_value, display_changed, sound_active,
					bad_opcode, key_waiting});
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

endmodule
